### src/radix_integer_to_ascii_unit_assert.svh
// Assertion macros shared by the radix integer-to-ASCII unit.
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge out of reset.
`define RITOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ritoa assertion failed");
// Next-cycle implication, checked at every clock edge out of reset.
`define RITOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ritoa assertion failed");
`else
`define RITOA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RITOA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/ritoa_pkg.sv
// Shared types, constants and tables of the radix integer-to-ASCII unit.
`default_nettype none

package ritoa_pkg;

  localparam int FIELD_BITS = 32;
  localparam int RADIX_BITS = 5;
  localparam int CHAR_BITS  = 7;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd26;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_BITS-1:0] DIGIT_DEC_MAX = 5'd9;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_BITS-1:0]  DEC_DIGITS  = 7'd10;

  // One queued conversion job: the raw value and the radix it was taken with.
  typedef struct packed {
    logic [FIELD_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
  } job_t;

  // floor(2^32 / r) for the legal radixes; zero for the others.
  function automatic logic [FIELD_BITS-1:0] recip32(input logic [RADIX_BITS-1:0] r);
    logic [FIELD_BITS-1:0] m;
    case (r)
      5'd2:    m = 32'd2147483648;
      5'd3:    m = 32'd1431655765;
      5'd4:    m = 32'd1073741824;
      5'd5:    m = 32'd858993459;
      5'd6:    m = 32'd715827882;
      5'd7:    m = 32'd613566756;
      5'd8:    m = 32'd536870912;
      5'd9:    m = 32'd477218588;
      5'd10:   m = 32'd429496729;
      5'd11:   m = 32'd390451572;
      5'd12:   m = 32'd357913941;
      5'd13:   m = 32'd330382099;
      5'd14:   m = 32'd306783378;
      5'd15:   m = 32'd286331153;
      5'd16:   m = 32'd268435456;
      5'd17:   m = 32'd252645135;
      5'd18:   m = 32'd238609294;
      5'd19:   m = 32'd226050910;
      5'd20:   m = 32'd214748364;
      5'd21:   m = 32'd204522252;
      5'd22:   m = 32'd195225786;
      5'd23:   m = 32'd186737708;
      5'd24:   m = 32'd178956970;
      5'd25:   m = 32'd171798691;
      5'd26:   m = 32'd165191049;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Digit value to its ASCII character: 0..9 as decimal digits, then letters.
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d > DIGIT_DEC_MAX) begin
      c = CHAR_UPPER_A - DEC_DIGITS + {2'b00, d};
    end else begin
      c = CHAR_ZERO + {2'b00, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/ritoa_ifs.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface ritoa_in_if;
  logic                              valid;
  logic                              ready;
  logic [ritoa_pkg::FIELD_BITS-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ritoa_out_if;
  logic                              valid;
  logic                              ready;
  logic [ritoa_pkg::CHAR_BITS-1:0]   ascii_char;
  logic                              last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

`default_nettype wire

### src/ritoa_front.sv
// Front end: holds the radix register, accepts input words and queues legal jobs.
`default_nettype none

module ritoa_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ritoa_pkg::RADIX_BITS-1:0]  cfg_wdata,
  ritoa_in_if.sink                               in_chan,
  output      logic                              push_valid,
  input  wire logic                              push_ready,
  output      ritoa_pkg::job_t                   push_data
);

  logic [ritoa_pkg::RADIX_BITS-1:0] radix_r;
  logic [ritoa_pkg::RADIX_BITS-1:0] radix_nxt;
  logic                             radix_ok;

  always_comb begin
    radix_nxt = cfg_we ? cfg_wdata : radix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= ritoa_pkg::RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // A word taken under an illegal radix is consumed and produces nothing.
  assign radix_ok = (radix_r >= ritoa_pkg::RADIX_MIN) && (radix_r <= ritoa_pkg::RADIX_MAX);

  assign in_chan.ready   = push_ready;
  assign push_valid      = in_chan.valid && radix_ok;
  assign push_data.value = in_chan.value;
  assign push_data.radix = radix_r;

endmodule

`default_nettype wire

### src/ritoa_fifo.sv
// Two-entry job queue between the front end and the conversion engine.
`default_nettype none
`include "radix_integer_to_ascii_unit_assert.svh"

module ritoa_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire ritoa_pkg::job_t  push_data,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      ritoa_pkg::job_t  pop_data
);

  localparam logic [1:0] DEPTH = 2'd2;

  ritoa_pkg::job_t mem_r [2];
  ritoa_pkg::job_t mem_nxt [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != DEPTH);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    mem_nxt    = mem_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      mem_nxt[wr_ptr_r] = push_data;
      wr_ptr_nxt        = ~wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    mem_r <= mem_nxt;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // The fill level must not exceed the depth, and the pointers must stay apart by the fill level modulo two.
  `RITOA_ASSERT_IMP(a_fifo_ptr_gap, clk, rst_n, 1'b1, (cnt_r <= DEPTH) && ((wr_ptr_r ^ rd_ptr_r) == cnt_r[0]))

endmodule

`default_nettype wire

### src/ritoa_back.sv
// Conversion engine: reciprocal division into a digit stack, then character output.
`default_nettype none
`include "radix_integer_to_ascii_unit_assert.svh"

module ritoa_back #(
  parameter int QUOT_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  output      logic             pop_ready,
  input  wire ritoa_pkg::job_t  pop_data,
  ritoa_out_if.source           out_chan
);

  localparam int CNT_BITS = $clog2(QUOT_BITS + 1);
  localparam int RB = ritoa_pkg::RADIX_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_FIX, ST_EMIT} state_t;

  state_t                               state_r, state_nxt;
  logic [QUOT_BITS-1:0]                 quot_r, quot_nxt;
  logic [QUOT_BITS-1:0]                 recip_r, recip_nxt;
  logic [QUOT_BITS-1:0]                 qest_r, qest_nxt;
  logic [RB-1:0]                        radix_r, radix_nxt;
  logic [QUOT_BITS-1:0][RB-1:0]         stack_r, stack_nxt;
  logic [CNT_BITS-1:0]                  cnt_r, cnt_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [ritoa_pkg::CHAR_BITS-1:0]      out_char_r, out_char_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic [ritoa_pkg::FIELD_BITS-1:0]     recip_full;
  logic [2*QUOT_BITS-1:0]               prod;
  logic [5:0]                           rem_raw;
  logic                                 rem_ge;
  logic [5:0]                           rem_fix;
  logic [RB-1:0]                        digit;
  logic [QUOT_BITS-1:0]                 quot_div;
  logic                                 out_load;

  assign recip_full = ritoa_pkg::recip32(pop_data.radix);
  assign prod       = {{QUOT_BITS{1'b0}}, quot_r} * {{QUOT_BITS{1'b0}}, recip_r};

  // The estimate is the true quotient or one below, so the remainder is
  // below twice the radix; one conditional subtract finishes the division.
  assign rem_raw  = quot_r[5:0] - 6'(qest_r[5:0] * {1'b0, radix_r});
  assign rem_ge   = (rem_raw >= {1'b0, radix_r});
  assign rem_fix  = rem_ge ? (rem_raw - {1'b0, radix_r}) : rem_raw;
  assign digit    = rem_fix[RB-1:0];
  assign quot_div = qest_r + {{(QUOT_BITS-1){1'b0}}, rem_ge};

  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);
  assign pop_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    quot_nxt      = quot_r;
    recip_nxt     = recip_r;
    qest_nxt      = qest_r;
    radix_nxt     = radix_r;
    stack_nxt     = stack_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          quot_nxt  = pop_data.value[QUOT_BITS-1:0];
          radix_nxt = pop_data.radix;
          recip_nxt = recip_full[ritoa_pkg::FIELD_BITS-1 -: QUOT_BITS];
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        qest_nxt  = prod[2*QUOT_BITS-1:QUOT_BITS];
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        // A zero value runs this once and stacks the single digit zero.
        stack_nxt = {stack_r[QUOT_BITS-2:0], digit};
        quot_nxt  = quot_div;
        cnt_nxt   = cnt_r + CNT_BITS'(1);
        state_nxt = (quot_div == '0) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ritoa_pkg::digit_char(stack_r[0]);
          out_last_nxt  = (cnt_r == CNT_BITS'(1));
          stack_nxt     = {{RB{1'b0}}, stack_r[QUOT_BITS-1:1]};
          cnt_nxt       = cnt_r - CNT_BITS'(1);
          if (cnt_r == CNT_BITS'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    quot_r     <= quot_nxt;
    recip_r    <= recip_nxt;
    qest_r     <= qest_nxt;
    radix_r    <= radix_nxt;
    stack_r    <= stack_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ascii_char = out_char_r;
  assign out_chan.last       = out_last_r;

  `RITOA_ASSERT_IMP(a_rem_below_twice_radix, clk, rst_n, state_r == ST_FIX, rem_raw < ({1'b0, radix_r} << 1))
  `RITOA_ASSERT_NXT(a_last_ends_job, clk, rst_n, out_load && (cnt_r == CNT_BITS'(1)), (state_r == ST_IDLE) && out_chan.last)
  `RITOA_ASSERT_IMP(a_digit_count_bound, clk, rst_n, 1'b1, cnt_r <= CNT_BITS'(QUOT_BITS))

endmodule

`default_nettype wire

### src/radix_integer_to_ascii_unit.sv
// Top level of the radix integer-to-ASCII unit: front end, job queue and engine.
`default_nettype none

//  Channel   Direction  Handshake              Contents
//  in_chan   sink       valid/ready            value, unsigned integer word
//  out_chan  source     valid/ready            ascii_char per digit, last ends a word
//  cfg       write      cfg_we, no wait        cfg_wdata, radix register
//
// A job leaves the queue, then each digit takes one pass of the divide loop
// (reciprocal multiply, then remainder correction), and each digit is then
// emitted as one character; the digit count is at most VALUE_BITS
// (capped at 32), and a zero value gives one digit.
// Reset is synchronous and active low; the radix comes up as 10.
// The two-entry queue lets the input side take words while the engine is
// busy or the result side is stalled; a stall on out_chan holds the engine.

module radix_integer_to_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ritoa_pkg::RADIX_BITS-1:0]  cfg_wdata,
  ritoa_in_if.sink                               in_chan,
  ritoa_out_if.source                            out_chan
);

  // Only the low VALUE_BITS of the word take part; the field itself is 32 bits,
  // so the divider never needs to be wider than that.
  localparam int QUOT_BITS = (VALUE_BITS < ritoa_pkg::FIELD_BITS) ?
                             VALUE_BITS : ritoa_pkg::FIELD_BITS;

  logic             push_valid;
  logic             push_ready;
  ritoa_pkg::job_t  push_data;
  logic             pop_valid;
  logic             pop_ready;
  ritoa_pkg::job_t  pop_data;

  // The front end checks the radix; words under an illegal radix are
  // accepted and dropped here, so they never reach the queue.
  ritoa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ritoa_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The engine collects digits least significant first on a stack and
  // pops them back out most significant first, flagging the final one.
  ritoa_back #(
    .QUOT_BITS (QUOT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire
